// File: hdl/vtv_pkg.sv
package vtv_pkg;

  // Default field widths of the coordinates and the matrix coefficients.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF  = 16;

  // Fraction bits of the fixed-point formats.
  localparam int COEF_FRAC  = 12;
  localparam int COORD_FRAC = 8;

  // Clip values wider than this many product bits are shifted down first.
  localparam int CLIP_LIMIT = 49;

  // Quotient bits produced by the divider: 14 magnitude bits plus one overflow bit.
  localparam int QUOT_BITS = 15;

  localparam int SCREEN_W = 13;
  localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = -13'sd4096;
  localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = 13'sd4095;

  localparam int VP_W      = 12;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL0   = 4'd0,
    REG_COL1   = 4'd1,
    REG_COL2   = 4'd2,
    REG_COL3   = 4'd3,
    REG_VP_X   = 4'd4,
    REG_VP_Y   = 4'd5,
    REG_VP_WID = 4'd6,
    REG_VP_HGT = 4'd7
  } cfg_reg_e;

  // Identity matrix in Q3.12 at the default coefficient width.
  localparam logic [CFG_DATA_W-1:0] COL0_RST = 64'd4096;
  localparam logic [CFG_DATA_W-1:0] COL1_RST = 64'd268435456;
  localparam logic [CFG_DATA_W-1:0] COL2_RST = 64'd17592186044416;
  localparam logic [CFG_DATA_W-1:0] COL3_RST = 64'd1152921504606846976;
  localparam logic [VP_W-1:0] VP_WID_RST = 12'd1280;
  localparam logic [VP_W-1:0] VP_HGT_RST = 12'd720;

endpackage

// File: hdl/vtv_div_step.sv
module vtv_div_step #(
  parameter int NUM_W   = 64,
  parameter int DIV_W   = 50,
  parameter int SHIFT   = 0
) (
  input  logic [NUM_W-1:0] rem_i,
  input  logic [DIV_W-1:0] div_i,
  output logic [NUM_W-1:0] rem_o,
  output logic             bit_o
);

  // One restoring step: try to take the shifted divisor out of the remainder.
  logic [NUM_W:0] dsh;

  always_comb begin
    dsh = (NUM_W+1)'(div_i) << SHIFT;
    if ({1'b0, rem_i} >= dsh) begin
      rem_o = rem_i - dsh[NUM_W-1:0];
      bit_o = 1'b1;
    end else begin
      rem_o = rem_i;
      bit_o = 1'b0;
    end
  end

endmodule

// File: hdl/vertex_transform_viewport.sv
// Channel     Direction  Content
// s_axis      in         one vertex item: x, y, z (signed fixed point)
// m_axis      out        one screen item: screen x, screen y, plus w-zero and clamp flags
// cfg         in         register writes: matrix columns and viewport
//
// Every accepted vertex yields exactly one screen item, which passes through four
// arithmetic stages, 15 divider stages and one output register.
// Unless stalled, one item is taken per cycle; the pipelined divider sets the rate,
// retiring one quotient bit per stage for the x and y coordinates in parallel.
// Reset clears only the valid bits and loads the configuration registers with defaults.
// When the output item is not taken, the whole pipeline holds in place.
module vertex_transform_viewport
  import vtv_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  localparam int IN_W = ((3*COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vertex_x, vertex_y, vertex_z from the lowest bit up, zero padded
  input  logic [IN_W-1:0]       s_axis_tdata,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // screen_x, screen_y from the lowest bit up, zero padded
  output logic [31:0]           m_axis_tdata,
  // w_zero, saturated from the lowest bit up
  output logic [1:0]            m_axis_tuser,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Derived widths.
  localparam int PROD_W  = COEF_WIDTH + COORD_WIDTH;
  localparam int ACC_W   = PROD_W + 2;
  localparam int REDUCE  = (PROD_W > CLIP_LIMIT) ? (PROD_W - CLIP_LIMIT) : 0;
  localparam int CLIP_W  = ACC_W - REDUCE;
  localparam int VPP_W   = CLIP_W + VP_W + 1;
  localparam int NUM_W   = CLIP_W + VP_W + 2;
  localparam int EXT_W   = (4*COEF_WIDTH > CFG_DATA_W) ? 4*COEF_WIDTH : CFG_DATA_W;
  localparam int NS      = QUOT_BITS;

  // Configuration registers. Writes are always taken.
  logic [CFG_DATA_W-1:0] col_q [4];
  logic [VP_W-1:0] vp_x_q, vp_y_q, vp_wid_q, vp_hgt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q[0] <= COL0_RST;
      col_q[1] <= COL1_RST;
      col_q[2] <= COL2_RST;
      col_q[3] <= COL3_RST;
      vp_x_q   <= '0;
      vp_y_q   <= '0;
      vp_wid_q <= VP_WID_RST;
      vp_hgt_q <= VP_HGT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COL0:   col_q[0] <= cfg_data_i;
        REG_COL1:   col_q[1] <= cfg_data_i;
        REG_COL2:   col_q[2] <= cfg_data_i;
        REG_COL3:   col_q[3] <= cfg_data_i;
        REG_VP_X:   vp_x_q   <= cfg_data_i[VP_W-1:0];
        REG_VP_Y:   vp_y_q   <= cfg_data_i[VP_W-1:0];
        REG_VP_WID: vp_wid_q <= cfg_data_i[VP_W-1:0];
        REG_VP_HGT: vp_hgt_q <= cfg_data_i[VP_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one: it advances whenever the output register is free
  // or is being emptied in this cycle.
  logic out_vld_q;
  logic adv;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Coefficient fetch. Row r of column c sits at bit r*COEF_WIDTH; bits beyond
  // the 64-bit register read as zero. Only rows 0, 1 and 3 are needed, since
  // clip z plays no part in the screen position.
  logic signed [COEF_WIDTH-1:0] coef [4][3];

  always_comb begin
    logic [EXT_W-1:0] ext;
    for (int c = 0; c < 4; c++) begin
      ext = EXT_W'(col_q[c]);
      for (int i = 0; i < 3; i++) begin
        coef[c][i] = ext[((i == 2) ? 3 : i)*COEF_WIDTH +: COEF_WIDTH];
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] vin [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vin[c] = s_axis_tdata[c*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // Stage A: nine products and the three translation terms (w is one).
  logic                     va_q;
  logic signed [PROD_W-1:0] prod_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[i][c] <= PROD_W'(coef[c][i]) * PROD_W'(vin[c]);
        end
        prod_q[i][3] <= PROD_W'(coef[3][i]) <<< COORD_FRAC;
      end
    end
  end

  // Stage B: row sums, reduced by a flooring shift when the products are wide.
  logic                     vb_q;
  logic signed [CLIP_W-1:0] clip_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [ACC_W-1:0] acc;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        acc = ACC_W'(prod_q[i][0]) + ACC_W'(prod_q[i][1])
            + ACC_W'(prod_q[i][2]) + ACC_W'(prod_q[i][3]);
        clip_q[i] <= CLIP_W'(acc >>> REDUCE);
      end
    end
  end

  // Stage C: viewport scale and offset products. Half sizes use integer halves.
  logic signed [VP_W-1:0]   half_w, half_h;
  logic signed [VP_W:0]     off_x, off_y;

  assign half_w = $signed({1'b0, vp_wid_q[VP_W-1:1]});
  assign half_h = $signed({1'b0, vp_hgt_q[VP_W-1:1]});
  assign off_x  = (VP_W+1)'($signed(vp_x_q)) + (VP_W+1)'(half_w);
  assign off_y  = (VP_W+1)'($signed(vp_y_q)) + (VP_W+1)'(half_h);

  logic                     vc_q;
  logic signed [VPP_W-1:0]  px_s_q, px_o_q, py_s_q, py_o_q;
  logic signed [CLIP_W-1:0] cw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_s_q <= VPP_W'(half_w) * VPP_W'(clip_q[0]);
      px_o_q <= VPP_W'(off_x)  * VPP_W'(clip_q[2]);
      py_s_q <= VPP_W'(half_h) * VPP_W'(clip_q[1]);
      py_o_q <= VPP_W'(off_y)  * VPP_W'(clip_q[2]);
      cw_q   <= clip_q[2];
    end
  end

  // Stage D: numerators, then sign and magnitude for the unsigned divider.
  // Index 0 of the divider arrays is this stage; index j follows step j.
  logic [NUM_W-1:0]  rx_q   [NS+1];
  logic [NUM_W-1:0]  ry_q   [NS+1];
  logic [CLIP_W-1:0] dv_q   [NS+1];
  logic [NS-1:0]     qx_q   [NS+1];
  logic [NS-1:0]     qy_q   [NS+1];
  logic              negx_q [NS+1];
  logic              negy_q [NS+1];
  logic              zero_q [NS+1];
  logic              vd_q   [NS+1];

  logic signed [NUM_W-1:0] num_x, num_y;

  assign num_x = NUM_W'(px_s_q) + NUM_W'(px_o_q);
  assign num_y = NUM_W'(py_o_q) - NUM_W'(py_s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q[0] <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q[0]   <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      ry_q[0]   <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
      dv_q[0]   <= cw_q[CLIP_W-1] ? CLIP_W'(-cw_q) : CLIP_W'(cw_q);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      negx_q[0] <= num_x[NUM_W-1] ^ cw_q[CLIP_W-1];
      negy_q[0] <= num_y[NUM_W-1] ^ cw_q[CLIP_W-1];
      zero_q[0] <= (cw_q == '0);
    end
  end

  // Divider: one quotient bit per stage, most significant first. The top bit
  // only marks a quotient too large for the screen range.
  for (genvar j = 1; j <= NS; j++) begin : g_div
    logic [NUM_W-1:0] rem_x, rem_y;
    logic             bit_x, bit_y;

    vtv_div_step #(
      .NUM_W (NUM_W),
      .DIV_W (CLIP_W),
      .SHIFT (NS - j)
    ) u_step_x (
      .rem_i (rx_q[j-1]),
      .div_i (dv_q[j-1]),
      .rem_o (rem_x),
      .bit_o (bit_x)
    );

    vtv_div_step #(
      .NUM_W (NUM_W),
      .DIV_W (CLIP_W),
      .SHIFT (NS - j)
    ) u_step_y (
      .rem_i (ry_q[j-1]),
      .div_i (dv_q[j-1]),
      .rem_o (rem_y),
      .bit_o (bit_y)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j] <= 1'b0;
      end else if (adv) begin
        vd_q[j] <= vd_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx_q[j]   <= rem_x;
        ry_q[j]   <= rem_y;
        dv_q[j]   <= dv_q[j-1];
        qx_q[j]   <= {qx_q[j-1][NS-2:0], bit_x};
        qy_q[j]   <= {qy_q[j-1][NS-2:0], bit_y};
        negx_q[j] <= negx_q[j-1];
        negy_q[j] <= negy_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
  end

  // Output stage: restore the sign, clamp to the screen range, and force
  // zeros when clip w was zero.
  logic signed [SCREEN_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic                       satx, saty;
  logic                       wz_q, sat_q;

  always_comb begin
    logic [NS-2:0] mx, my;
    mx = qx_q[NS][NS-2:0];
    my = qy_q[NS][NS-2:0];
    satx = 1'b0;
    saty = 1'b0;
    if (negx_q[NS]) begin
      if (qx_q[NS][NS-1] || (mx > (NS-1)'(4096))) begin
        sx_d = SCREEN_MIN;
        satx = 1'b1;
      end else begin
        sx_d = SCREEN_W'(-$signed({1'b0, mx}));
      end
    end else begin
      if (qx_q[NS][NS-1] || (mx > (NS-1)'(4095))) begin
        sx_d = SCREEN_MAX;
        satx = 1'b1;
      end else begin
        sx_d = SCREEN_W'(mx);
      end
    end
    if (negy_q[NS]) begin
      if (qy_q[NS][NS-1] || (my > (NS-1)'(4096))) begin
        sy_d = SCREEN_MIN;
        saty = 1'b1;
      end else begin
        sy_d = SCREEN_W'(-$signed({1'b0, my}));
      end
    end else begin
      if (qy_q[NS][NS-1] || (my > (NS-1)'(4095))) begin
        sy_d = SCREEN_MAX;
        saty = 1'b1;
      end else begin
        sy_d = SCREEN_W'(my);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vd_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (zero_q[NS]) begin
        sx_q  <= '0;
        sy_q  <= '0;
        wz_q  <= 1'b1;
        sat_q <= 1'b0;
      end else begin
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        wz_q  <= 1'b0;
        sat_q <= satx | saty;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, sy_q, sx_q};
  assign m_axis_tuser  = {sat_q, wz_q};

endmodule
